// ----- rtl/double_ended_queue_macros.svh -----
// Assertion macros for the double-ended queue.
// Included by double_ended_queue, which carries the concurrent checks; needs clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DEQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Used by deq_cell and double_ended_queue; depends on nothing.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 8;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_READ_AT    = 3'd2,
        REQ_WRITE_AT   = 3'd3,
        REQ_READ_BACK  = 3'd4,
        REQ_WRITE_BACK = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
// Bounded double-ended queue of signed words: top level with control and result register.
// Depends on deq_pkg, deq_cell and double_ended_queue_macros.svh.
//
// Each request is accepted when start is high and its result appears on the following cycle with
// done high for exactly that cycle; busy never rises, so a request may be issued on every
// clock. Storage is a row of cells kept in logical order, front at cell zero: a push to
// the front moves every element one cell back in the same cycle, all other requests touch
// at most one cell. The result must be taken when done is high; it is not held.
`include "double_ended_queue_macros.svh"

module double_ended_queue
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            req_type,
    input  logic [deq_pkg::POS_W-1:0]             position,
    input  logic signed [deq_pkg::DATA_WIDTH-1:0] data_in,
    output logic                                  done,
    output logic signed [deq_pkg::DATA_WIDTH-1:0] data_out,
    output logic [1:0]                            status,
    output logic [deq_pkg::CNT_W-1:0]             occupancy,
    output logic                                  is_empty
);

    logic signed [deq_pkg::DATA_WIDTH-1:0] cell_value [deq_pkg::DEPTH];
    deq_pkg::cell_ctrl_t                   cell_ctrl  [deq_pkg::DEPTH];

    logic [deq_pkg::CNT_W-1:0] count_reg;
    logic [deq_pkg::CNT_W-1:0] count_next;
    logic [deq_pkg::CNT_W-1:0] count_m1;
    logic                      full;
    logic                      accept;
    logic                      shift_en;
    logic                      wr_en;
    logic [deq_pkg::IDX_W-1:0] wr_idx;
    logic                      rd_en;
    logic [deq_pkg::IDX_W-1:0] rd_idx;
    logic                      pos_bad;
    deq_pkg::status_t          status_next;

    logic                                  done_reg;
    logic signed [deq_pkg::DATA_WIDTH-1:0] data_out_reg;
    logic signed [deq_pkg::DATA_WIDTH-1:0] data_out_next;
    deq_pkg::status_t                      status_reg;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign full     = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign count_m1 = count_reg - deq_pkg::CNT_W'(1);
    assign pos_bad  = ({{(deq_pkg::POS_W - deq_pkg::CNT_W){1'b0}}, count_reg} <= position);

    always_comb
    begin
        count_next  = count_reg;
        shift_en    = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        rd_en       = 1'b0;
        rd_idx      = '0;
        status_next = deq_pkg::ST_OK;
        if (accept)
        begin
            case (deq_pkg::req_t'(req_type))
                deq_pkg::REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = count_reg[deq_pkg::IDX_W-1:0];
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::REQ_READ_AT:
                begin
                    if (pos_bad)
                    begin
                        status_next = deq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = position[deq_pkg::IDX_W-1:0];
                    end
                end
                deq_pkg::REQ_WRITE_AT:
                begin
                    if (pos_bad)
                    begin
                        status_next = deq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_idx = position[deq_pkg::IDX_W-1:0];
                    end
                end
                deq_pkg::REQ_READ_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = deq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = count_m1[deq_pkg::IDX_W-1:0];
                    end
                end
                deq_pkg::REQ_WRITE_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = deq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_idx = count_m1[deq_pkg::IDX_W-1:0];
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    assign data_out_next = rd_en ? cell_value[rd_idx] : '0;

    for (genvar i = 0; i < deq_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [deq_pkg::DATA_WIDTH-1:0] shift_src;

        if (i == 0)
        begin : g_head
            assign shift_src = data_in;
        end
        else
        begin : g_body
            assign shift_src = cell_value[i-1];
        end

        assign cell_ctrl[i].shift = shift_en;
        assign cell_ctrl[i].load  = wr_en && (wr_idx == deq_pkg::IDX_W'(i));

        deq_cell u_cell
        (
            .clk      (clk),
            .ctrl     (cell_ctrl[i]),
            .shift_in (shift_src),
            .data_in  (data_in),
            .value    (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
    end

    assign done      = done_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = count_reg;
    assign is_empty  = (count_reg == '0);

    `DEQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `DEQ_ASSERT(a_count_bound, count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "count exceeds depth")
    `DEQ_ASSERT(a_done_follows, accept |=> done, "accepted item gave no result")
    `DEQ_ASSERT(a_full_status, (done && status == deq_pkg::ST_FULL) |-> (occupancy == deq_pkg::CNT_W'(deq_pkg::DEPTH)), "full status while not full")
    `DEQ_ASSERT(a_err_zero, (done && status != deq_pkg::ST_OK) |-> (data_out == '0), "error result carries data")
    `DEQ_ASSERT(a_count_step, (count_reg != $past(count_reg)) |-> ($past(accept) && count_reg == $past(count_reg) + deq_pkg::CNT_W'(1)), "count moved without a push")

endmodule

// ----- rtl/deq_cell.sv -----
// One storage cell of the queue chain: holds the element at one logical position.
// Depends on deq_pkg for widths and the control struct.
module deq_cell
(
    input  logic                                  clk,
    input  deq_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [deq_pkg::DATA_WIDTH-1:0] shift_in,
    input  logic signed [deq_pkg::DATA_WIDTH-1:0] data_in,
    output logic signed [deq_pkg::DATA_WIDTH-1:0] value
);

    logic signed [deq_pkg::DATA_WIDTH-1:0] value_reg;
    logic signed [deq_pkg::DATA_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = shift_in;
        end
        else if (ctrl.load)
        begin
            value_next = data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
